// File: design/ttag_pkg.sv
// Shared constants, types and helper functions for the transpose address generator.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package ttag_pkg;

	localparam int MAX_DIMS     = 4;
	localparam int LENGTH_BITS  = 16;
	localparam int DIM_W        = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
	localparam int CNT_W        = 3;
	localparam int LEN_REG_W    = 64;
	localparam int PERM_W       = 8;
	localparam int PERM_FIELD   = 2;
	localparam int PERM_ENTRIES = PERM_W / PERM_FIELD;
	localparam int ESZ_W        = 2;
	localparam int OFF_W        = 32;
	localparam int BYTE_W       = 35;
	localparam int CFG_W        = 64;
	localparam int CFG_IDX_W    = 3;
	localparam int QUEUE_DEPTH  = 2;
	localparam int QPTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

	localparam logic [CNT_W-1:0]     RST_DIM_COUNT   = CNT_W'(4);
	localparam logic [LEN_REG_W-1:0] RST_DIM_LENGTHS = 64'h0001_0001_0001_0001;
	localparam logic [PERM_W-1:0]    RST_PERM_PACKED = 8'h1B;
	localparam logic                 RST_REVERSE     = 1'b1;
	localparam logic [ESZ_W-1:0]     RST_ELEM_SIZE   = ESZ_W'(0);

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_DIM_COUNT       = 3'd0,
		CFG_DIM_LENGTHS     = 3'd1,
		CFG_PERM_PACKED     = 3'd2,
		CFG_REVERSE_DEFAULT = 3'd3,
		CFG_ELEM_SIZE_LOG2  = 3'd4
	} ttag_cfg_idx_t;

	typedef struct packed {
		logic [CNT_W-1:0]                      dn;
		logic [MAX_DIMS-1:0][LENGTH_BITS-1:0]  olen;
		logic [MAX_DIMS-1:0][OFF_W-1:0]        delta;
		logic [ESZ_W-1:0]                      esz;
	} ttag_tables_t;

	typedef struct packed {
		logic             restart;
		logic [DIM_W-1:0] lvl;
		logic             last;
	} ttag_step_t;

	function automatic logic [CNT_W-1:0] dims_used(input logic [CNT_W-1:0] dim_count);
		if (dim_count == '0)
			return CNT_W'(1);
		if (int'(dim_count) > MAX_DIMS)
			return CNT_W'(MAX_DIMS);
		return dim_count;
	endfunction

	function automatic logic [DIM_W-1:0] perm_of(
		input logic [DIM_W-1:0]  i,
		input logic [CNT_W-1:0]  dn,
		input logic              rev,
		input logic [PERM_W-1:0] perm
	);
		logic [CNT_W-1:0] r;
		r = dn - CNT_W'(1) - CNT_W'(i);
		if (rev)
			return r[DIM_W-1:0];
		if (int'(i) < PERM_ENTRIES)
			return DIM_W'(perm[PERM_FIELD*i +: PERM_FIELD]);
		return i;
	endfunction

	function automatic logic [LENGTH_BITS-1:0] in_length(
		input logic [DIM_W-1:0]     d,
		input logic [CNT_W-1:0]     dn,
		input logic [LEN_REG_W-1:0] lengths
	);
		logic [LENGTH_BITS-1:0] v;
		if (CNT_W'(d) >= dn || LENGTH_BITS * (int'(d) + 1) > LEN_REG_W)
			return LENGTH_BITS'(1);
		v = lengths[LENGTH_BITS*d +: LENGTH_BITS];
		return (v == '0) ? LENGTH_BITS'(1) : v;
	endfunction

endpackage

`default_nettype wire

// File: design/ttag_if.sv
// Valid/ready channel interfaces for the input tick and the output offset pair.
// Depends on ttag_pkg for payload widths.
`default_nettype none

interface ttag_in_if;
	logic valid;
	logic ready;
	logic restart;

	modport source (output valid, output restart, input ready);
	modport sink   (input valid, input restart, output ready);
endinterface

interface ttag_out_if import ttag_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] src_byte_offset;
	logic [BYTE_W-1:0] dst_byte_offset;
	logic              last;

	modport source (output valid, output src_byte_offset, output dst_byte_offset,
		output last, input ready);
	modport sink   (input valid, input src_byte_offset, input dst_byte_offset,
		input last, output ready);
endinterface

`default_nettype wire

// File: design/ttag_setup.sv
// Configuration registers and the setup sequencer that derives output lengths and
// per-level source offset steps with 32x16 multiplies. Depends on ttag_pkg.
`default_nettype none

module ttag_setup import ttag_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	output ttag_tables_t         tables,
	output logic                 busy
);

	typedef enum logic [4:0] {
		S_LOAD   = 5'b00001,
		S_STRIDE = 5'b00010,
		S_DMUL   = 5'b00100,
		S_DADD   = 5'b01000,
		S_IDLE   = 5'b10000
	} ttag_setup_state_t;

	ttag_setup_state_t state_q;

	logic [CNT_W-1:0]     dim_count_q;
	logic [LEN_REG_W-1:0] dim_lengths_q;
	logic [PERM_W-1:0]    perm_packed_q;
	logic                 reverse_default_q;
	logic [ESZ_W-1:0]     elem_size_log2_q;

	logic [DIM_W-1:0]               idx_q;
	logic [OFF_W-1:0]               acc_q;
	logic [OFF_W-1:0]               sum_q;
	logic [OFF_W-1:0]               prod_q;
	logic [MAX_DIMS-1:0][OFF_W-1:0] stride_q;
	ttag_tables_t                   tables_q;

	logic [CNT_W-1:0]                     dn_cfg;
	logic [CNT_W-1:0]                     dn_cfg_m1;
	logic [CNT_W-1:0]                     dn_tab_m1;
	logic [MAX_DIMS-1:0][LENGTH_BITS-1:0] olen_load;
	logic [DIM_W-1:0]                     perm_i;
	logic [OFF_W-1:0]                     sst;
	logic [LENGTH_BITS-1:0]               len_k;
	logic [LENGTH_BITS-1:0]               olen_m1;
	ttag_cfg_idx_t                        cfg_sel;
	logic                                 cfg_hit;

	always_comb begin
		dn_cfg    = dims_used(dim_count_q);
		dn_cfg_m1 = dn_cfg - CNT_W'(1);
		dn_tab_m1 = tables_q.dn - CNT_W'(1);
		for (int i = 0; i < MAX_DIMS; i++) begin
			if (CNT_W'(i) < dn_cfg)
				olen_load[i] = in_length(perm_of(DIM_W'(i), dn_cfg, reverse_default_q,
					perm_packed_q), dn_cfg, dim_lengths_q);
			else
				olen_load[i] = LENGTH_BITS'(1);
		end
		perm_i  = perm_of(idx_q, tables_q.dn, reverse_default_q, perm_packed_q);
		sst     = stride_q[perm_i];
		len_k   = in_length(idx_q, tables_q.dn, dim_lengths_q);
		olen_m1 = tables_q.olen[idx_q] - LENGTH_BITS'(1);
	end

	always_comb begin
		cfg_sel = ttag_cfg_idx_t'(cfg_index);
		unique case (cfg_sel) inside
			CFG_DIM_COUNT, CFG_DIM_LENGTHS, CFG_PERM_PACKED,
			CFG_REVERSE_DEFAULT, CFG_ELEM_SIZE_LOG2: cfg_hit = 1'b1;
			default:                                 cfg_hit = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q           <= S_LOAD;
			idx_q             <= '0;
			dim_count_q       <= RST_DIM_COUNT;
			dim_lengths_q     <= RST_DIM_LENGTHS;
			perm_packed_q     <= RST_PERM_PACKED;
			reverse_default_q <= RST_REVERSE;
			elem_size_log2_q  <= RST_ELEM_SIZE;
		end else begin
			unique case (state_q)
				S_LOAD: begin
					idx_q   <= dn_cfg_m1[DIM_W-1:0];
					state_q <= S_STRIDE;
				end
				S_STRIDE: begin
					if (idx_q == '0) begin
						idx_q   <= dn_tab_m1[DIM_W-1:0];
						state_q <= S_DMUL;
					end else begin
						idx_q <= idx_q - DIM_W'(1);
					end
				end
				S_DMUL: state_q <= S_DADD;
				S_DADD: begin
					if (idx_q == '0) begin
						state_q <= S_IDLE;
					end else begin
						idx_q   <= idx_q - DIM_W'(1);
						state_q <= S_DMUL;
					end
				end
				S_IDLE: ;
				default: state_q <= S_LOAD;
			endcase
			if (cfg_we && cfg_hit) begin
				state_q <= S_LOAD;
				unique case (cfg_sel)
					CFG_DIM_COUNT:       dim_count_q       <= cfg_data[CNT_W-1:0];
					CFG_DIM_LENGTHS:     dim_lengths_q     <= cfg_data[LEN_REG_W-1:0];
					CFG_PERM_PACKED:     perm_packed_q     <= cfg_data[PERM_W-1:0];
					CFG_REVERSE_DEFAULT: reverse_default_q <= cfg_data[0];
					CFG_ELEM_SIZE_LOG2:  elem_size_log2_q  <= cfg_data[ESZ_W-1:0];
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_LOAD: begin
				tables_q.dn   <= dn_cfg;
				tables_q.olen <= olen_load;
				tables_q.esz  <= elem_size_log2_q;
				stride_q      <= '0;
				acc_q         <= OFF_W'(1);
				sum_q         <= '0;
			end
			S_STRIDE: begin
				stride_q[idx_q] <= acc_q;
				acc_q           <= OFF_W'(acc_q * len_k);
			end
			S_DMUL: begin
				prod_q                <= OFF_W'(sst * olen_m1);
				tables_q.delta[idx_q] <= sst - sum_q;
			end
			S_DADD: sum_q <= sum_q + prod_q;
			default: ;
		endcase
	end

	assign tables = tables_q;
	assign busy   = (state_q != S_IDLE);

endmodule

`default_nettype wire

// File: design/ttag_front.sv
// Front end: accepts tick beats, holds the output position counters and classifies
// each beat by the dimension that carries into. Depends on ttag_pkg and ttag_if.
`default_nettype none

module ttag_front import ttag_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	ttag_in_if.sink      tick,
	input  ttag_tables_t tables,
	input  logic         busy,
	input  logic         q_full,
	output logic         q_push,
	output ttag_step_t   q_entry
);

	logic [MAX_DIMS-1:0][LENGTH_BITS-1:0] pos_q;
	logic [MAX_DIMS-1:0][LENGTH_BITS-1:0] base;
	logic [MAX_DIMS-1:0][LENGTH_BITS-1:0] pos_next;
	logic [MAX_DIMS-1:0]                  wrap;
	logic [DIM_W-1:0]                     lvl;
	logic                                 last;
	logic                                 accept;

	assign tick.ready = !busy && !q_full;
	assign accept     = tick.valid && tick.ready;

	always_comb begin
		lvl = '0;
		for (int k = 0; k < MAX_DIMS; k++) begin
			base[k] = tick.restart ? '0 : pos_q[k];
			wrap[k] = (CNT_W'(k) >= tables.dn) ||
				(base[k] >= tables.olen[k] - LENGTH_BITS'(1));
			if (!wrap[k])
				lvl = DIM_W'(k);
		end
		last = &wrap;
		for (int k = 0; k < MAX_DIMS; k++) begin
			if (last || DIM_W'(k) > lvl)
				pos_next[k] = '0;
			else if (DIM_W'(k) == lvl)
				pos_next[k] = base[k] + LENGTH_BITS'(1);
			else
				pos_next[k] = base[k];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (busy) begin
			pos_q <= '0;
		end else if (accept) begin
			pos_q <= pos_next;
		end
	end

	assign q_push  = accept;
	assign q_entry = '{restart: tick.restart, lvl: lvl, last: last};

`ifndef SYNTHESIS
	a_last_clears_pos: assert property (@(posedge clk) disable iff (!arst_n)
		accept && last |=> pos_q == '0)
		else $error("position counters not cleared after final beat");

	for (genvar g = 0; g < MAX_DIMS; g++) begin : g_pos_chk
		a_pos_in_range: assert property (@(posedge clk) disable iff (!arst_n)
			!busy |-> pos_q[g] < tables.olen[g])
			else $error("position counter beyond output length");
	end
`endif

endmodule

`default_nettype wire

// File: design/ttag_queue.sv
// Short FIFO of classified steps between the front end and the offset back end.
// Depends on ttag_pkg.
`default_nettype none

module ttag_queue import ttag_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  ttag_step_t push_entry,
	input  logic       pop,
	output logic       valid,
	output logic       full,
	output ttag_step_t head
);

	ttag_step_t        mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	assign valid = (count_q != '0);
	assign full  = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign head  = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + QPTR_W'(1);
			if (pop)
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + QPTR_W'(1);
			if (push && !pop)
				count_q <= count_q + QCNT_W'(1);
			else if (pop && !push)
				count_q <= count_q - QCNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_entry;
	end

endmodule

`default_nettype wire

// File: design/ttag_back.sv
// Back end: running source/destination element offsets, byte scaling and the
// output register of the pair channel. Depends on ttag_pkg and ttag_if.
`default_nettype none

module ttag_back import ttag_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  ttag_tables_t tables,
	input  logic         busy,
	input  logic         q_valid,
	input  ttag_step_t   q_head,
	output logic         q_pop,
	ttag_out_if.source   pair
);

	logic              out_valid_q;
	logic [BYTE_W-1:0] src_q;
	logic [BYTE_W-1:0] dst_q;
	logic              last_q;
	logic [OFF_W-1:0]  s_q;
	logic [OFF_W-1:0]  t_q;
	logic [OFF_W-1:0]  cs;
	logic [OFF_W-1:0]  ct;

	assign q_pop = q_valid && (!out_valid_q || pair.ready);
	assign cs    = q_head.restart ? '0 : s_q;
	assign ct    = q_head.restart ? '0 : t_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			s_q         <= '0;
			t_q         <= '0;
		end else begin
			if (q_pop)
				out_valid_q <= 1'b1;
			else if (pair.ready)
				out_valid_q <= 1'b0;
			if (busy) begin
				s_q <= '0;
				t_q <= '0;
			end else if (q_pop) begin
				s_q <= q_head.last ? '0 : cs + tables.delta[q_head.lvl];
				t_q <= q_head.last ? '0 : ct + OFF_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			src_q  <= BYTE_W'(cs) << tables.esz;
			dst_q  <= BYTE_W'(ct) << tables.esz;
			last_q <= q_head.last;
		end
	end

	assign pair.valid           = out_valid_q;
	assign pair.src_byte_offset = src_q;
	assign pair.dst_byte_offset = dst_q;
	assign pair.last            = last_q;

`ifndef SYNTHESIS
	a_last_wraps: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop && q_head.last |=> s_q == '0 && t_q == '0)
		else $error("offsets not wrapped after final beat");

	a_dst_steps: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop && !busy && !q_head.last && !q_head.restart |=> t_q == $past(t_q) + OFF_W'(1))
		else $error("destination offset did not advance by one element");
`endif

endmodule

`default_nettype wire

// File: design/tensor_transpose_address_gen_unit.sv
// Top level of the N-dimensional transpose address generator.
// Depends on ttag_pkg, ttag_if, ttag_setup, ttag_front, ttag_queue and ttag_back.
`default_nettype none

// Each tick beat yields one pair beat: the byte offset to read in the row-major input
// tensor and the byte offset to write in the row-major transposed output, with last on
// the final element, after which the walk starts over. Steady state is one pair per
// clock while pair.ready stays high. Tick passes through a 2-entry queue and an
// output register on its way to pair; these let tick keep flowing while pair stalls
// briefly. After reset and after every accepted register write, a setup pass over
// the dimensions in use (at most 4) derives the per-dimension offset steps with
// 32x16 multiplies; tick.ready is low during that pass and the walk restarts from
// element zero. Write registers only when no pairs are outstanding.

module tensor_transpose_address_gen_unit import ttag_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	ttag_in_if.sink              tick,
	ttag_out_if.source           pair
);

	ttag_tables_t tables;
	logic         busy;
	logic         q_push;
	logic         q_pop;
	logic         q_valid;
	logic         q_full;
	ttag_step_t   q_entry;
	ttag_step_t   q_head;

	ttag_setup u_setup (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.tables    (tables),
		.busy      (busy)
	);

	ttag_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.tick    (tick),
		.tables  (tables),
		.busy    (busy),
		.q_full  (q_full),
		.q_push  (q_push),
		.q_entry (q_entry)
	);

	ttag_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_entry (q_entry),
		.pop        (q_pop),
		.valid      (q_valid),
		.full       (q_full),
		.head       (q_head)
	);

	ttag_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.tables  (tables),
		.busy    (busy),
		.q_valid (q_valid),
		.q_head  (q_head),
		.q_pop   (q_pop),
		.pair    (pair)
	);

endmodule

`default_nettype wire
